// ----- rtl/core/crcfc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the frame checker.
package crcfc_pkg;

    localparam int unsigned HDR_BYTES     = 16;
    localparam int unsigned TRAILER_BYTES = 8;
    localparam int unsigned MIN_FRAME     = HDR_BYTES + TRAILER_BYTES;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    localparam logic [31:0] PREFIX_RESET  = 32'h0000_55AA;
    localparam logic [31:0] SUFFIX_RESET  = 32'h0000_AA55;

    // configuration register indexes
    localparam logic REG_PREFIX = 1'b0;
    localparam logic REG_SUFFIX = 1'b1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        STATUS_OK        = 4'd0,
        STATUS_SHORT     = 4'd1,
        STATUS_LONG      = 4'd2,
        STATUS_PREFIX    = 4'd3,
        STATUS_LEN_SMALL = 4'd4,
        STATUS_SIZE      = 4'd5,
        STATUS_BODY_BIG  = 4'd6,
        STATUS_SUFFIX    = 4'd7,
        STATUS_CRC       = 4'd8
    } frame_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic          result_kind;
        logic [7:0]    payload_byte;
        logic [9:0]    payload_index;
        frame_status_t status;
        logic [31:0]   sequence_number;
        logic [31:0]   command_code;
        logic [9:0]    payload_length;
        logic [31:0]   frame_crc;
    } result_t;

    // Reflected CRC-32 update by one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/crcfc_in_stage.sv -----
// Input register stage: holds one accepted request until the core takes it.
module crcfc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // data_byte[7:0]
    input  logic                s_tlast,    // frame_end
    input  logic                advance,
    output logic                in_valid,
    output crcfc_pkg::in_item_t in_item
);

    logic                in_valid_reg;
    logic                in_valid_next;
    crcfc_pkg::in_item_t in_item_reg;

    // free when empty or when the held request moves on this cycle
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.frame_end <= s_tlast;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_item  = in_item_reg;

endmodule

// ----- rtl/core/crcfc_core.sv -----
// Frame state, header capture, delayed CRC and end-of-frame checks.
module crcfc_core #(
    parameter int unsigned MAX_FRAME_BYTES = 1024,
    parameter int unsigned MAX_BODY_BYTES  = 1016
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  crcfc_pkg::in_item_t item,
    input  logic [31:0]         prefix_word,
    input  logic [31:0]         suffix_word,
    output logic                res_valid,
    output crcfc_pkg::result_t  res
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [31:0]      MAX_FRM  = 32'(MAX_FRAME_BYTES);
    localparam logic [31:0]      MAX_BODY = 32'(MAX_BODY_BYTES);

    logic [CNT_W-1:0] count_reg,  count_next;
    logic [31:0]      crc_reg,    crc_next;
    logic [63:0]      recent_reg, recent_next;
    logic [31:0]      seen_prefix_reg,   seen_prefix_next;
    logic [31:0]      seen_sequence_reg, seen_sequence_next;
    logic [31:0]      seen_command_reg,  seen_command_next;
    logic [31:0]      seen_length_reg,   seen_length_next;

    logic [31:0]      pos;
    logic [31:0]      size;
    logic [31:0]      body_idx;
    logic [31:0]      body_len;
    logic [CNT_W-1:0] count_upd;
    logic [31:0]      crc_upd;
    logic [63:0]      recent_upd;
    logic [31:0]      prefix_upd, sequence_upd, command_upd, length_upd;
    crcfc_pkg::frame_status_t status_code;

    always_comb begin
        pos          = 32'(count_reg);
        prefix_upd   = seen_prefix_reg;
        sequence_upd = seen_sequence_reg;
        command_upd  = seen_command_reg;
        length_upd   = seen_length_reg;

        if (pos < crcfc_pkg::HDR_BYTES) begin
            case (count_reg[3:2])
                2'd0:    prefix_upd   = {seen_prefix_reg[23:0], item.data_byte};
                2'd1:    sequence_upd = {seen_sequence_reg[23:0], item.data_byte};
                2'd2:    command_upd  = {seen_command_reg[23:0], item.data_byte};
                default: length_upd   = {seen_length_reg[23:0], item.data_byte};
            endcase
        end

        // feed the byte leaving the eight-byte window
        crc_upd = crc_reg;
        if (pos >= crcfc_pkg::TRAILER_BYTES) begin
            crc_upd = crcfc_pkg::crc_byte(crc_reg, recent_reg[63:56]);
        end
        recent_upd = {recent_reg[55:0], item.data_byte};

        count_upd = (count_reg == CNT_SAT) ? count_reg : count_reg + 1'b1;
        size      = 32'(count_upd);
        body_idx  = pos - crcfc_pkg::HDR_BYTES;
        body_len  = length_upd - crcfc_pkg::TRAILER_BYTES;

        // checks in priority order, first failure wins
        if (size < crcfc_pkg::MIN_FRAME) begin
            status_code = crcfc_pkg::STATUS_SHORT;
        end else if (size > MAX_FRM) begin
            status_code = crcfc_pkg::STATUS_LONG;
        end else if (prefix_upd != prefix_word) begin
            status_code = crcfc_pkg::STATUS_PREFIX;
        end else if (length_upd < crcfc_pkg::TRAILER_BYTES) begin
            status_code = crcfc_pkg::STATUS_LEN_SMALL;
        end else if (({1'b0, length_upd} + 33'(crcfc_pkg::HDR_BYTES)) != {1'b0, size}) begin
            status_code = crcfc_pkg::STATUS_SIZE;
        end else if (body_len > MAX_BODY) begin
            status_code = crcfc_pkg::STATUS_BODY_BIG;
        end else if (recent_upd[31:0] != suffix_word) begin
            status_code = crcfc_pkg::STATUS_SUFFIX;
        end else if (recent_upd[63:32] != ~crc_upd) begin
            status_code = crcfc_pkg::STATUS_CRC;
        end else begin
            status_code = crcfc_pkg::STATUS_OK;
        end

        res       = '0;
        res_valid = 1'b0;
        if (!item.frame_end) begin
            if (pos >= crcfc_pkg::HDR_BYTES && pos < MAX_FRM
                    && length_upd >= crcfc_pkg::TRAILER_BYTES
                    && body_idx < body_len && body_idx < MAX_BODY) begin
                res_valid         = 1'b1;
                res.result_kind   = crcfc_pkg::KIND_PAYLOAD;
                res.payload_byte  = item.data_byte;
                res.payload_index = body_idx[9:0];
            end
        end else begin
            res_valid           = 1'b1;
            res.result_kind     = crcfc_pkg::KIND_STATUS;
            res.status          = status_code;
            res.sequence_number = sequence_upd;
            res.command_code    = command_upd;
            res.payload_length  = (status_code == crcfc_pkg::STATUS_OK) ? body_len[9:0] : 10'd0;
            res.frame_crc       = recent_upd[63:32];
        end

        // drop all frame state after the status
        if (item.frame_end) begin
            count_next         = '0;
            crc_next           = crcfc_pkg::CRC_INIT;
            recent_next        = '0;
            seen_prefix_next   = '0;
            seen_sequence_next = '0;
            seen_command_next  = '0;
            seen_length_next   = '0;
        end else begin
            count_next         = count_upd;
            crc_next           = crc_upd;
            recent_next        = recent_upd;
            seen_prefix_next   = prefix_upd;
            seen_sequence_next = sequence_upd;
            seen_command_next  = command_upd;
            seen_length_next   = length_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            crc_reg           <= crcfc_pkg::CRC_INIT;
            recent_reg        <= '0;
            seen_prefix_reg   <= '0;
            seen_sequence_reg <= '0;
            seen_command_reg  <= '0;
            seen_length_reg   <= '0;
        end else if (advance) begin
            count_reg         <= count_next;
            crc_reg           <= crc_next;
            recent_reg        <= recent_next;
            seen_prefix_reg   <= seen_prefix_next;
            seen_sequence_reg <= seen_sequence_next;
            seen_command_reg  <= seen_command_next;
            seen_length_reg   <= seen_length_next;
        end
    end

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.frame_end |=> count_reg == '0 && crc_reg == crcfc_pkg::CRC_INIT)
        else $error("frame state not cleared after last byte");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_SAT)
        else $error("byte count beyond saturation");

    a_end_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        item.frame_end |-> res_valid && res.result_kind == crcfc_pkg::KIND_STATUS)
        else $error("last byte without status result");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.result_kind == crcfc_pkg::KIND_PAYLOAD |->
            res.status == crcfc_pkg::STATUS_OK && res.payload_length == 10'd0
            && !item.frame_end)
        else $error("payload result carries status fields");

endmodule

// ----- rtl/core/crcfc_out_stage.sv -----
// Output register: holds one result until the downstream side takes it.
module crcfc_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               res_valid,
    input  crcfc_pkg::result_t res,
    input  logic               m_tready,
    output logic               m_tvalid,
    // payload_byte[7:0], payload_index[17:8], status[21:18], sequence_number[53:22],
    // command_code[85:54], payload_length[95:86], frame_crc[127:96]
    output logic [127:0]       m_tdata,
    output logic               m_tuser     // result_kind
);

    logic               out_valid_reg;
    logic               out_valid_next;
    crcfc_pkg::result_t out_res_reg;

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.result_kind;
    assign m_tdata  = {out_res_reg.frame_crc,
                       out_res_reg.payload_length,
                       out_res_reg.command_code,
                       out_res_reg.sequence_number,
                       out_res_reg.status,
                       out_res_reg.payload_index,
                       out_res_reg.payload_byte};

endmodule

// ----- rtl/core/crc32_frame_checker.sv -----
// Top level of the CRC-32 frame checker: config registers and stage wiring.
// A request accepted into the input register moves through the core into the output register, which drives m_tvalid.
// Throughput: one byte per cycle while the output register is free or draining; the byte-wide CRC update and the header
// and trailer checks sit between the input register and the output register.
// A result held by the consumer holds the byte behind it, also a byte that gives no result.
// Reset (aresetn low, synchronous) clears frame state and restores the markers.
module crc32_frame_checker #(
    parameter int unsigned MAX_FRAME_BYTES = 1024,
    parameter int unsigned MAX_BODY_BYTES  = 1016
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // data_byte[7:0]
    input  logic         s_tlast,     // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // payload_byte[7:0], payload_index[17:8], status[21:18], sequence_number[53:22],
    // command_code[85:54], payload_length[95:86], frame_crc[127:96]
    output logic [127:0] m_tdata,
    output logic         m_tuser,     // result_kind
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic                in_valid;
    crcfc_pkg::in_item_t in_item;
    logic                advance;
    logic                res_valid;
    crcfc_pkg::result_t  res;
    logic [31:0]         prefix_word_reg;
    logic [31:0]         suffix_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_word_reg <= crcfc_pkg::PREFIX_RESET;
            suffix_word_reg <= crcfc_pkg::SUFFIX_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == crcfc_pkg::REG_PREFIX) begin
                prefix_word_reg <= cfg_wdata;
            end else if (cfg_index == crcfc_pkg::REG_SUFFIX) begin
                suffix_word_reg <= cfg_wdata;
            end
        end
    end

    // move the held byte on when the output slot is free or draining
    assign advance = in_valid && (!m_tvalid || m_tready);

    crcfc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    crcfc_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_BODY_BYTES  (MAX_BODY_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item),
        .prefix_word (prefix_word_reg),
        .suffix_word (suffix_word_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    crcfc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for crc32_frame_checker against a byte-level predictor.
module tb;

    localparam int unsigned FRAME_MAX   = 1024;
    localparam int unsigned BODY_MAX    = 1016;
    localparam int unsigned QUIET_LIMIT = 2000;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'd0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = crcfc_pkg::REG_PREFIX;
    logic [31:0]  cfg_wdata = 32'd0;

    // stimulus and scoreboard
    crcfc_pkg::in_item_t tx_bytes[$];
    crcfc_pkg::in_item_t next_req;
    crcfc_pkg::result_t  want_results[$];
    logic [7:0]   frame_buf[$];
    int unsigned  queued_count;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  tx_wait        = 0;
    int unsigned  rx_wait        = 0;
    int unsigned  tx_mode        = 0;
    int unsigned  rx_mode        = 0;

    // predictor state and register copies
    logic [31:0]  cfg_prefix = crcfc_pkg::PREFIX_RESET;
    logic [31:0]  cfg_suffix = crcfc_pkg::SUFFIX_RESET;
    logic [31:0]  fr_count;
    logic [31:0]  crc_acc;
    logic [63:0]  window;
    logic [31:0]  hdr_prefix;
    logic [31:0]  hdr_seq;
    logic [31:0]  hdr_cmd;
    logic [31:0]  hdr_length;

    crc32_frame_checker #(
        .MAX_FRAME_BYTES(FRAME_MAX),
        .MAX_BODY_BYTES (BODY_MAX)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // reflected CRC-32, one data bit per round, LSB first
    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb) acc = acc ^ crcfc_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    function automatic int unsigned draw_wait(input int unsigned mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default: return $urandom_range(0, 19);
        endcase
    endfunction

    function automatic string show(input crcfc_pkg::result_t r);
        return $sformatf({"kind=%0d byte=%02h idx=%0d status=%0d seq=%08h cmd=%08h",
                          " len=%0d crc=%08h"},
                         r.result_kind, r.payload_byte, r.payload_index, r.status,
                         r.sequence_number, r.command_code, r.payload_length, r.frame_crc);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    task automatic restart_frame();
        fr_count   = 32'd0;
        crc_acc    = crcfc_pkg::CRC_INIT;
        window     = 64'd0;
        hdr_prefix = 32'd0;
        hdr_seq    = 32'd0;
        hdr_cmd    = 32'd0;
        hdr_length = 32'd0;
    endtask

    // Advance the frame state by one accepted byte and queue what it yields.
    task automatic track_byte(input logic [7:0] b, input logic fin);
        logic [31:0]              pos;
        logic [31:0]              size;
        logic [31:0]              q;
        logic [31:0]              body;
        crcfc_pkg::frame_status_t st;
        crcfc_pkg::result_t       r;
        pos = fr_count;
        if (pos < crcfc_pkg::HDR_BYTES) begin
            case (pos[3:2])
                2'd0: hdr_prefix = {hdr_prefix[23:0], b};
                2'd1: hdr_seq    = {hdr_seq[23:0], b};
                2'd2: hdr_cmd    = {hdr_cmd[23:0], b};
                default: hdr_length = {hdr_length[23:0], b};
            endcase
        end
        // the CRC trails the input by the eight trailer bytes
        if (pos >= crcfc_pkg::TRAILER_BYTES) crc_acc = crc_fold(crc_acc, window[63:56]);
        window = {window[55:0], b};
        size = pos + 1;
        if (size > FRAME_MAX + 1) size = FRAME_MAX + 1;
        fr_count = size;
        r = '0;
        if (!fin) begin
            if (pos >= crcfc_pkg::HDR_BYTES && pos < FRAME_MAX
                    && hdr_length >= crcfc_pkg::TRAILER_BYTES) begin
                q = pos - crcfc_pkg::HDR_BYTES;
                if (q < hdr_length - crcfc_pkg::TRAILER_BYTES && q < BODY_MAX) begin
                    r.result_kind   = crcfc_pkg::KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = q[9:0];
                    want_results.push_back(r);
                end
            end
        end else begin
            body = hdr_length - crcfc_pkg::TRAILER_BYTES;
            if (size < crcfc_pkg::MIN_FRAME) st = crcfc_pkg::STATUS_SHORT;
            else if (size > FRAME_MAX) st = crcfc_pkg::STATUS_LONG;
            else if (hdr_prefix != cfg_prefix) st = crcfc_pkg::STATUS_PREFIX;
            else if (hdr_length < crcfc_pkg::TRAILER_BYTES) st = crcfc_pkg::STATUS_LEN_SMALL;
            else if (64'(hdr_length) + 64'(crcfc_pkg::HDR_BYTES) != 64'(size))
                st = crcfc_pkg::STATUS_SIZE;
            else if (body > BODY_MAX) st = crcfc_pkg::STATUS_BODY_BIG;
            else if (window[31:0] != cfg_suffix) st = crcfc_pkg::STATUS_SUFFIX;
            else if (window[63:32] != ~crc_acc) st = crcfc_pkg::STATUS_CRC;
            else st = crcfc_pkg::STATUS_OK;
            r.result_kind     = crcfc_pkg::KIND_STATUS;
            r.status          = st;
            r.sequence_number = hdr_seq;
            r.command_code    = hdr_cmd;
            r.payload_length  = (st == crcfc_pkg::STATUS_OK) ? body[9:0] : 10'd0;
            r.frame_crc       = window[63:32];
            want_results.push_back(r);
            restart_frame();
        end
    endtask

    task automatic check_result(input logic kind, input logic [127:0] d);
        crcfc_pkg::result_t got;
        crcfc_pkg::result_t exp;
        got.result_kind     = kind;
        got.payload_byte    = d[7:0];
        got.payload_index   = d[17:8];
        got.status          = crcfc_pkg::frame_status_t'(d[21:18]);
        got.sequence_number = d[53:22];
        got.command_code    = d[85:54];
        got.payload_length  = d[95:86];
        got.frame_crc       = d[127:96];
        if (want_results.size() == 0) begin
            note_failure($sformatf("unexpected result: %s", show(got)));
        end else begin
            exp = want_results.pop_front();
            if (got.result_kind !== exp.result_kind || got.payload_byte !== exp.payload_byte ||
                got.payload_index !== exp.payload_index || got.status !== exp.status ||
                got.sequence_number !== exp.sequence_number ||
                got.command_code !== exp.command_code ||
                got.payload_length !== exp.payload_length || got.frame_crc !== exp.frame_crc)
                note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                       show(exp), show(got)));
        end
    endtask

    // driver: one request in flight, random gap before each new one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
            restart_frame();
        end else begin
            if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    next_req = tx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.data_byte;
                    s_tlast  <= next_req.frame_end;
                    tx_wait = draw_wait(tx_mode);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result, then stall for a random stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tuser, m_tdata);
                rx_wait = draw_wait(rx_mode);
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) quiet_cycles++;
        else quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void push_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) frame_buf.push_back(w[8 * k +: 8]);
    endfunction

    // Assemble header, random body, CRC and suffix; crc_err flips CRC bits.
    task automatic build_frame(input logic [31:0] pfx, input logic [31:0] seq,
                               input logic [31:0] cmd, input logic [31:0] lenw,
                               input int unsigned nbody, input logic [31:0] sfx,
                               input logic [31:0] crc_err);
        logic [31:0] c;
        frame_buf.delete();
        push_word(pfx);
        push_word(seq);
        push_word(cmd);
        push_word(lenw);
        repeat (nbody) frame_buf.push_back(8'($urandom_range(0, 255)));
        c = crcfc_pkg::CRC_INIT;
        foreach (frame_buf[i]) c = crc_fold(c, frame_buf[i]);
        push_word(~c ^ crc_err);
        push_word(sfx);
    endtask

    // Queue the first keep bytes of the frame (all when keep is 0 or not below the frame size), last one flagged.
    task automatic send_frame(input int unsigned keep);
        int unsigned         n;
        crcfc_pkg::in_item_t it;
        n = (keep > 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
        for (int unsigned i = 0; i < n; i++) begin
            it.data_byte = frame_buf[i];
            it.frame_end = (i == n - 1);
            tx_bytes.push_back(it);
        end
        queued_count += n;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned nbody;
        logic [31:0] lenw;
        logic [31:0] pfx;
        logic [31:0] sfx;
        logic [31:0] cx;
        int unsigned keep;
        pick  = $urandom_range(0, 99);
        nbody = ($urandom_range(0, 59) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        lenw  = nbody + crcfc_pkg::TRAILER_BYTES;
        pfx   = cfg_prefix;
        sfx   = cfg_suffix;
        cx    = 32'd0;
        keep  = 0;
        if (pick >= 94) begin
            // line noise
            frame_buf.delete();
            repeat ($urandom_range(1, 48)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (pick >= 60 && pick < 66) cx = 32'd1 << $urandom_range(0, 31);
            else if (pick >= 66 && pick < 72) pfx = pfx ^ (32'd1 << $urandom_range(0, 31));
            else if (pick >= 72 && pick < 78) sfx = sfx ^ (32'd1 << $urandom_range(0, 31));
            else if (pick >= 78 && pick < 84) lenw = lenw ^ (32'd1 << $urandom_range(0, 31));
            else if (pick >= 84 && pick < 88) lenw = $urandom_range(0, 7);
            build_frame(pfx, $urandom, $urandom, lenw, nbody, sfx, cx);
            // truncated frame
            if (pick >= 88) keep = $urandom_range(1, frame_buf.size() - 1);
        end
        send_frame(keep);
    endtask

    task automatic fill_random(input int unsigned budget);
        queued_count = 0;
        while (queued_count < budget) random_frame();
    endtask

    // Hold off until the sender is empty and every result is in, then let the pipe settle.
    task automatic drain();
        do @(negedge aclk);
        while (tx_bytes.size() != 0 || s_tvalid || want_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == crcfc_pkg::REG_PREFIX) cfg_prefix = val;
        else cfg_suffix = val;
    endtask

    task automatic set_markers(input logic [31:0] pfx, input logic [31:0] sfx);
        write_reg(crcfc_pkg::REG_PREFIX, pfx);
        write_reg(crcfc_pkg::REG_SUFFIX, sfx);
        @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames under the reset markers
        tx_mode = 2;
        rx_mode = 2;
        build_frame(crcfc_pkg::PREFIX_RESET, 32'd0, 32'd0, 32'd8, 0,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9, 1,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        // oversize length field: every byte past the header but the last is passed on
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'hFFFF_FFFF, 40,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, 32'h1234_5678, 32'h9ABC_DEF0, 32'd8, 0,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(1);
        send_frame(10);
        send_frame(23);
        build_frame(crcfc_pkg::PREFIX_RESET ^ 32'h8000_0000, $urandom, $urandom, 32'd12, 4,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd0, 0,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd7, 0,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd20, 3,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd10, 3,
                    crcfc_pkg::SUFFIX_RESET, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd13, 5,
                    crcfc_pkg::SUFFIX_RESET ^ 32'd1, 32'd0);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd14, 6,
                    crcfc_pkg::SUFFIX_RESET, 32'h0000_0001);
        send_frame(0);
        build_frame(crcfc_pkg::PREFIX_RESET, $urandom, $urandom, 32'd10, 2,
                    crcfc_pkg::SUFFIX_RESET, 32'h8000_0000);
        send_frame(0);
        drain();

        // extreme markers, sender at full rate
        set_markers(32'h0000_0000, 32'hFFFF_FFFF);
        tx_mode = 0;
        rx_mode = 1;
        build_frame(32'h0000_0000, 32'd0, 32'd0, 32'd8, 0, 32'hFFFF_FFFF, 32'd0);
        send_frame(0);
        fill_random(30);
        drain();

        set_markers(32'hFFFF_FFFF, 32'h0000_0000);
        tx_mode = 1;
        rx_mode = 0;
        build_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd11, 3, 32'd0, 32'd0);
        send_frame(0);
        fill_random(30);
        drain();

        for (int ph = 0; ph < 2; ph++) begin
            set_markers($urandom, $urandom);
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            fill_random(30);
            drain();
        end

        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && want_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
